// File: design/owlet_pkg.sv
// Shared constants, types and microcode control word of the label equivalence table.
package owlet_pkg;

   localparam int LABELS  = 1024;
   localparam int LABEL_W = 10;
   localparam int MEM_AW  = (LABELS > 1) ? $clog2(LABELS) : 1;
   localparam int CNT_W   = $clog2(LABELS + 1);

   typedef logic [LABEL_W-1:0] label_type;
   typedef logic [CNT_W-1:0]   count_type;

   typedef enum logic [1:0] {
      OP_ADD     = 2'd0,
      OP_RESOLVE = 2'd1,
      OP_FLATTEN = 2'd2,
      OP_NOP     = 2'd3
   } op_type;

   // Microprogram step addresses.
   typedef enum logic [4:0] {
      S_CLR,
      S_FETCH,
      S_DISPATCH,
      S_ADD_RD,
      S_ADD_WR,
      S_RES_INIT,
      S_WALK_RD,
      S_WALK_EV,
      S_RET,
      S_RES_SET,
      S_FL_INIT,
      S_FL_RD,
      S_FL_CHK,
      S_FL_WALK,
      S_FL_SKIP,
      S_FL_WR,
      S_EMIT
   } step_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_KEY,
      RD_CUR,
      RD_IDX
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_ADD,
      WR_FLAT,
      WR_CLEAR
   } wr_sel_type;

   typedef enum logic [1:0] {
      INIT_NONE,
      INIT_KEY,
      INIT_IDX
   } init_sel_type;

   typedef enum logic [3:0] {
      C_ALWAYS,
      C_ACCEPT,
      C_DISPATCH,
      C_WALK_MORE,
      C_IS_FLAT,
      C_IDX_END,
      C_RD_INVALID,
      C_IDX_LAST,
      C_OUT_FREE
   } cond_type;

   // One control word of the microprogram.
   typedef struct packed {
      logic         fetch;
      rd_sel_type   rd_sel;
      wr_sel_type   wr_sel;
      init_sel_type init_sel;
      logic         walk_step;
      logic         idx_clr;
      logic         idx_inc;
      logic         set_res;
      logic         emit;
      cond_type     cond;
      logic         stay;
      step_type     jmp;
   } cw_type;

   // Status flags from the datapath that the sequencer branches on.
   typedef struct packed {
      logic   walk_more;
      logic   rd_invalid;
      logic   idx_end;
      logic   idx_last;
      logic   out_free;
      logic   is_flat;
      op_type op;
   } stat_type;

endpackage

// File: design/owlet_if.sv
// Request and response channel interfaces of the label equivalence table.
interface owlet_req_if
   import owlet_pkg::*;
;
   logic      valid;
   logic      ready;
   logic [1:0] opcode;
   label_type key_label;
   label_type target_label;

   modport source (output valid, output opcode, output key_label, output target_label,
                   input ready);
   modport sink   (input valid, input opcode, input key_label, input target_label,
                   output ready);
endinterface

interface owlet_rsp_if
   import owlet_pkg::*;
;
   logic      valid;
   logic      ready;
   logic      inserted;
   label_type resolved_label;
   logic      walk_overflow;

   modport source (output valid, output inserted, output resolved_label,
                   output walk_overflow, input ready);
   modport sink   (input valid, input inserted, input resolved_label,
                   input walk_overflow, output ready);
endinterface

// File: design/owlet_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
module owlet_seq
   import owlet_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  stat_type stat,
   output cw_type   cw,
   output logic     accept
);

   step_type upc_ff, upc_in;
   logic     cond_true;
   step_type dispatch_target;

   // Control store.
   always_comb begin
      cw        = '0;
      cw.jmp    = S_FETCH;
      cw.cond   = C_ALWAYS;
      unique case (upc_ff)
         S_CLR: begin
            cw.wr_sel  = WR_CLEAR;
            cw.idx_inc = 1'b1;
            cw.cond    = C_IDX_LAST;
            cw.stay    = 1'b1;
            cw.jmp     = S_FETCH;
         end
         S_FETCH: begin
            cw.fetch = 1'b1;
            cw.cond  = C_ACCEPT;
            cw.stay  = 1'b1;
            cw.jmp   = S_DISPATCH;
         end
         S_DISPATCH: begin
            cw.cond = C_DISPATCH;
         end
         S_ADD_RD: begin
            cw.rd_sel = RD_KEY;
            cw.jmp    = S_ADD_WR;
         end
         S_ADD_WR: begin
            cw.wr_sel = WR_ADD;
            cw.jmp    = S_EMIT;
         end
         S_RES_INIT: begin
            cw.init_sel = INIT_KEY;
            cw.jmp      = S_WALK_RD;
         end
         S_WALK_RD: begin
            cw.rd_sel = RD_CUR;
            cw.jmp    = S_WALK_EV;
         end
         S_WALK_EV: begin
            cw.walk_step = 1'b1;
            cw.cond      = C_WALK_MORE;
            cw.jmp       = S_WALK_RD;
         end
         S_RET: begin
            cw.cond = C_IS_FLAT;
            cw.jmp  = S_FL_WR;
         end
         S_RES_SET: begin
            cw.set_res = 1'b1;
            cw.jmp     = S_EMIT;
         end
         S_FL_INIT: begin
            cw.idx_clr = 1'b1;
            cw.jmp     = S_FL_RD;
         end
         S_FL_RD: begin
            cw.rd_sel = RD_IDX;
            cw.cond   = C_IDX_END;
            cw.jmp    = S_EMIT;
         end
         S_FL_CHK: begin
            cw.cond = C_RD_INVALID;
            cw.jmp  = S_FL_SKIP;
         end
         S_FL_WALK: begin
            cw.init_sel = INIT_IDX;
            cw.jmp      = S_WALK_RD;
         end
         S_FL_SKIP: begin
            cw.idx_inc = 1'b1;
            cw.jmp     = S_FL_RD;
         end
         S_FL_WR: begin
            cw.wr_sel  = WR_FLAT;
            cw.idx_inc = 1'b1;
            cw.jmp     = S_FL_RD;
         end
         S_EMIT: begin
            cw.emit = 1'b1;
            cw.cond = C_OUT_FREE;
            cw.stay = 1'b1;
            cw.jmp  = S_FETCH;
         end
         default: begin
            cw.jmp = S_FETCH;
         end
      endcase
   end

   assign accept = req_valid & cw.fetch;

   always_comb begin
      unique case (stat.op)
         OP_ADD:     dispatch_target = S_ADD_RD;
         OP_RESOLVE: dispatch_target = S_RES_INIT;
         OP_FLATTEN: dispatch_target = S_FL_INIT;
         OP_NOP:     dispatch_target = S_EMIT;
         default:    dispatch_target = S_EMIT;
      endcase
   end

   always_comb begin
      unique case (cw.cond)
         C_ALWAYS:     cond_true = 1'b1;
         C_ACCEPT:     cond_true = accept;
         C_DISPATCH:   cond_true = 1'b1;
         C_WALK_MORE:  cond_true = stat.walk_more;
         C_IS_FLAT:    cond_true = stat.is_flat;
         C_IDX_END:    cond_true = stat.idx_end;
         C_RD_INVALID: cond_true = stat.rd_invalid;
         C_IDX_LAST:   cond_true = stat.idx_last;
         C_OUT_FREE:   cond_true = stat.out_free;
         default:      cond_true = 1'b1;
      endcase
   end

   // Next step.
   always_comb begin
      if (cw.cond == C_DISPATCH) begin
         upc_in = dispatch_target;
      end else if (cond_true) begin
         upc_in = cw.jmp;
      end else if (cw.stay) begin
         upc_in = upc_ff;
      end else begin
         upc_in = step_type'(upc_ff + 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= S_CLR;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// File: design/owlet_dp.sv
// Datapath: label map memory, chain walk registers, scan index and response register.
module owlet_dp
   import owlet_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cw_type     cw,
   input  logic       accept,
   input  logic [1:0] req_opcode,
   input  label_type  req_key_label,
   input  label_type  req_target_label,
   input  logic       rsp_ready,
   output stat_type   stat,
   output logic       rsp_valid,
   output logic       rsp_inserted,
   output label_type  rsp_resolved_label,
   output logic       rsp_walk_overflow
);

   // Each word holds the valid bit above the target label.
   logic [LABEL_W:0] map_mem_ff [LABELS];

   op_type    op_ff;
   label_type key_ff, tgt_ff;
   label_type start_ff, start_in;
   label_type cur_ff, cur_in;
   label_type prev_ff, prev_in;
   label_type wres_ff, wres_in;
   label_type res_ff, res_in;
   count_type steps_ff, steps_in;
   count_type idx_ff, idx_in;
   logic      ins_ff, ins_in;
   logic      ovf_ff, ovf_in;
   logic      rd_valid_ff;
   label_type rd_target_ff;

   logic              rsp_valid_ff;
   logic              rsp_ins_ff;
   label_type         rsp_res_ff;
   logic              rsp_ovf_ff;

   logic              rd_en;
   logic [MEM_AW-1:0] rd_addr;
   logic              wr_en;
   logic [MEM_AW-1:0] wr_addr;
   logic [LABEL_W:0]  wr_data;
   logic              add_ok;
   logic              has_entry;
   logic              at_cap;
   logic              out_free;
   label_type         idx_label;

   function automatic logic in_store(label_type label);
      return 32'(label) < LABELS;
   endfunction

   assign idx_label = label_type'(idx_ff);
   assign has_entry = in_store(cur_ff) & rd_valid_ff;
   assign at_cap    = (steps_ff == CNT_W'(LABELS));
   assign add_ok    = (key_ff != tgt_ff) & in_store(key_ff) & ~rd_valid_ff;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   assign stat.walk_more  = has_entry & ~at_cap & (rd_target_ff != start_ff);
   assign stat.rd_invalid = ~rd_valid_ff;
   assign stat.idx_end    = (idx_ff == CNT_W'(LABELS));
   assign stat.idx_last   = (idx_ff == CNT_W'(LABELS - 1));
   assign stat.out_free   = out_free;
   assign stat.is_flat    = (op_ff == OP_FLATTEN);
   assign stat.op         = op_ff;

   // Memory port control.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      case (cw.rd_sel)
         RD_KEY: begin
            rd_en   = 1'b1;
            rd_addr = MEM_AW'(key_ff);
         end
         RD_CUR: begin
            rd_en   = 1'b1;
            rd_addr = MEM_AW'(cur_ff);
         end
         RD_IDX: begin
            rd_en   = ~stat.idx_end;
            rd_addr = idx_ff[MEM_AW-1:0];
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[MEM_AW-1:0];
      wr_data = '0;
      case (cw.wr_sel)
         WR_ADD: begin
            wr_en   = add_ok;
            wr_addr = MEM_AW'(key_ff);
            wr_data = {1'b1, tgt_ff};
         end
         WR_FLAT: begin
            wr_en   = 1'b1;
            wr_data = {1'b1, wres_ff};
         end
         WR_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         {rd_valid_ff, rd_target_ff} <= map_mem_ff[rd_addr];
      end
   end

   // Walk, scan and result registers.
   always_comb begin
      start_in = start_ff;
      cur_in   = cur_ff;
      prev_in  = prev_ff;
      wres_in  = wres_ff;
      steps_in = steps_ff;
      res_in   = res_ff;
      ins_in   = ins_ff;
      ovf_in   = ovf_ff;
      idx_in   = idx_ff;

      if (accept) begin
         res_in = '0;
         ins_in = 1'b0;
         ovf_in = 1'b0;
      end

      case (cw.init_sel)
         INIT_KEY: begin
            start_in = key_ff;
            cur_in   = key_ff;
            prev_in  = key_ff;
            steps_in = '0;
         end
         INIT_IDX: begin
            start_in = idx_label;
            cur_in   = idx_label;
            prev_in  = idx_label;
            steps_in = '0;
         end
         default: begin
            steps_in = steps_ff;
         end
      endcase

      if (cw.walk_step) begin
         if (!has_entry) begin
            wres_in = cur_ff;
         end else if (at_cap) begin
            ovf_in  = 1'b1;
            wres_in = cur_ff;
         end else begin
            cur_in   = rd_target_ff;
            steps_in = steps_ff + 1'b1;
            if (rd_target_ff == start_ff) begin
               wres_in = prev_ff;
            end else begin
               prev_in = rd_target_ff;
            end
         end
      end

      if (cw.wr_sel == WR_ADD && add_ok) begin
         ins_in = 1'b1;
      end
      if (cw.set_res) begin
         res_in = wres_ff;
      end

      if (cw.idx_clr) begin
         idx_in = '0;
      end else if (cw.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= op_type'(req_opcode);
         key_ff <= req_key_label;
         tgt_ff <= req_target_label;
      end
      start_ff <= start_in;
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      wres_ff  <= wres_in;
      steps_ff <= steps_in;
      res_ff   <= res_in;
      ins_ff   <= ins_in;
      ovf_ff   <= ovf_in;
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cw.emit && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cw.emit && out_free) begin
         rsp_ins_ff <= ins_ff;
         rsp_res_ff <= res_ff;
         rsp_ovf_ff <= ovf_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_inserted       = rsp_ins_ff;
   assign rsp_resolved_label = rsp_res_ff;
   assign rsp_walk_overflow  = rsp_ovf_ff;

endmodule

// File: design/one_way_label_equivalence_table.sv
// Top level of the one-way label equivalence table.
//
// The block holds a directed map from label to label, one entry per label with a valid
// bit, kept together in a single-port-per-cycle memory of LABELS words. Each request
// item carries an opcode: add stores key to target when the two differ and the key has
// no entry yet, and answers inserted; resolve follows the chain from the key until it
// reaches a label without an entry, answering with the label just before the chain
// returns to the key if it does so; flatten rewrites every valid entry, in ascending
// label order, with its resolved label; the remaining opcode does nothing. Every
// request gives exactly one response item; fields that do not belong to the opcode are
// zero, and walk_overflow reports a walk that ran LABELS steps without ending (a cycle
// that avoids its start), flatten giving the OR over all its walks. After reset the
// block clears the memory, all LABELS words (1024 as built), one word a cycle, with
// ready held low. Control is a microprogram of seventeen steps, and the single
// memory with its registered read sets the pace: every chain link takes a read step
// and an evaluate step. A no-operation passes through fetch, dispatch and emit; an add
// reads the key's entry and then writes it; a resolve walks the chain and sets the
// result; a flatten reads each index in turn, skips an empty entry and walks and
// rewrites a valid one. A walk that comes back to its start saves the final read
// and evaluate. The response sits in an output register, so the next request is
// taken while a finished response still waits for ready.
module one_way_label_equivalence_table
   import owlet_pkg::*;
(
   input logic        clock,
   input logic        reset,
   owlet_req_if.sink   req_chan,
   owlet_rsp_if.source rsp_chan
);

   cw_type   cw;
   stat_type stat;
   logic     accept;

   owlet_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .stat      (stat),
      .cw        (cw),
      .accept    (accept)
   );

   owlet_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cw                 (cw),
      .accept             (accept),
      .req_opcode         (req_chan.opcode),
      .req_key_label      (req_chan.key_label),
      .req_target_label   (req_chan.target_label),
      .rsp_ready          (rsp_chan.ready),
      .stat               (stat),
      .rsp_valid          (rsp_chan.valid),
      .rsp_inserted       (rsp_chan.inserted),
      .rsp_resolved_label (rsp_chan.resolved_label),
      .rsp_walk_overflow  (rsp_chan.walk_overflow)
   );

   // Ready is only raised in the fetch step.
   assign req_chan.ready = cw.fetch;

   // The clearing pass follows reset, so no item is taken straight after it.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_chan.ready)
      else $error("request taken during the clearing pass");

   // One item at a time: the step after an accept never accepts again.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second item accepted while one is in work");

   // The memory is never read and written in the same step.
   a_single_port: assert property (@(posedge clock) disable iff (reset)
      !(cw.rd_sel != RD_NONE && cw.wr_sel != WR_NONE))
      else $error("memory read and write in one step");

   // An emit step with a free output register presents a response next cycle.
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      (cw.emit && stat.out_free) |=> rsp_chan.valid)
      else $error("emitted response not presented");

endmodule

// File: test/label_map_check_pkg.sv
// Scoreboard class that predicts and checks the response items of the label equivalence table.
package label_map_check_pkg;
   import owlet_pkg::*;

   class label_map_scoreboard;
      typedef struct packed {
         logic      inserted;
         label_type resolved_label;
         logic      walk_overflow;
      } answer_type;

      bit          entry_valid [LABELS];
      label_type   entry_target[LABELS];
      answer_type  expected_q[$];
      int unsigned op_seen[4];
      int unsigned stored_count;
      int unsigned overflow_count;
      int unsigned checked_count;
      int unsigned error_count;

      // Walks the map from start until it meets a label without an entry. A chain that
      // comes back to start answers with the label just before the return; a walk that
      // runs out of steps answers with the label reached and raises capped.
      function label_type follow_chain(input label_type start, output bit capped,
                                       output int links);
         label_type cur;
         label_type prev;
         cur    = start;
         prev   = start;
         capped = 1'b0;
         links  = 0;
         while (entry_valid[cur]) begin
            if (links >= LABELS) begin
               capped = 1'b1;
               return cur;
            end
            cur = entry_target[cur];
            links++;
            if (cur == start) return prev;
            prev = cur;
         end
         return cur;
      endfunction

      // Updates the map for an accepted request item and queues its expected response.
      function void note(input op_type op, input label_type key, input label_type target);
         answer_type answer;
         bit         capped;
         int         links;
         answer = '0;
         op_seen[op]++;
         case (op)
            OP_ADD: begin
               if (key != target && !entry_valid[key]) begin
                  entry_valid[key]  = 1'b1;
                  entry_target[key] = target;
                  answer.inserted   = 1'b1;
                  stored_count++;
               end
            end
            OP_RESOLVE: begin
               answer.resolved_label = follow_chain(key, capped, links);
               answer.walk_overflow  = capped;
            end
            OP_FLATTEN: begin
               // Later walks see the entries that this pass has already rewritten.
               for (int i = 0; i < LABELS; i++) begin
                  if (entry_valid[i]) begin
                     entry_target[i] = follow_chain(label_type'(i), capped, links);
                     if (capped) answer.walk_overflow = 1'b1;
                  end
               end
            end
            default: ;
         endcase
         if (answer.walk_overflow) overflow_count++;
         expected_q.push_back(answer);
      endfunction

      function void compare_field(input string name, input logic [LABEL_W-1:0] want,
                                  input logic [LABEL_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
         end
      endfunction

      // Compares one accepted response item with the oldest expectation.
      function void check(input logic inserted, input label_type resolved_label,
                          input logic walk_overflow);
         answer_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %0b/%0d/%0b",
                     $time, inserted, resolved_label, walk_overflow);
            error_count++;
            return;
         end
         want = expected_q.pop_front();
         checked_count++;
         compare_field("inserted", want.inserted, inserted);
         compare_field("resolved_label", want.resolved_label, resolved_label);
         compare_field("walk_overflow", want.walk_overflow, walk_overflow);
      endfunction
   endclass

endpackage

// File: test/one_way_label_equivalence_table_tb.sv
// Self-checking testbench of the one-way label equivalence table.
module one_way_label_equivalence_table_tb;
   import owlet_pkg::*;
   import label_map_check_pkg::*;

   // Keys of the random part mostly come from a window of this many labels, so that
   // chains of several links build up; each pressure phase uses a window of its own.
   localparam int WINDOW = 48;
   localparam int PHASE_ITEMS = 145;
   // A flatten walks the chain of every valid entry. Flattens whose walks would add up to
   // more links than this are sent as no-operations instead, which keeps the run short.
   localparam int FLATTEN_LINK_BUDGET = 8000;
   // A resolve that runs into a foreign cycle walks LABELS links before it stops, so only
   // this many of them are sent in the random part.
   localparam int CAPPED_RESOLVE_BUDGET = 30;
   // The watchdog limit lies well above the time that the slowest correct flatten within
   // the budget above runs without a handshake.
   localparam int QUIET_LIMIT = 250000;
   localparam int DRAIN_CYCLES = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;

   owlet_req_if req_chan ();
   owlet_rsp_if rsp_chan ();

   one_way_label_equivalence_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   label_map_scoreboard sb = new();

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned capped_resolves = 0;
   int unsigned quiet_cycles = 0;
   int unsigned items_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver decides at every falling edge whether it will take a response at the
   // next rising edge, so that stalls fall on every phase of the block's work.
   always @(negedge clock) begin
      rsp_chan.ready = ($urandom_range(99) >= rsp_stall_pct);
   end

   // Responses are sampled at the rising edge, before the block's registers move on.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check(rsp_chan.inserted, rsp_chan.resolved_label, rsp_chan.walk_overflow);
   end

   // The watchdog counts cycles in which neither channel completes a handshake.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Presents one request item. Idle cycles may come first, as the current pressure
   // phase asks; once valid is raised it stays high until the item is accepted, and the
   // scoreboard notes the item at the very edge that accepts it, so the map it holds is
   // up to date when the next item is chosen.
   task automatic send_item(input op_type op, input label_type key, input label_type target);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid        = 1'b1;
      req_chan.opcode       = op;
      req_chan.key_label    = key;
      req_chan.target_label = target;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note(op, key, target);
      items_sent++;
   endtask

   // Random items under one pressure setting. Most items are adds and resolves on the
   // window, with targets a few labels ahead of the key so that chains grow forwards;
   // now and then a target points back into the window and closes a cycle. The rest are
   // flattens, no-operations and adds on arbitrary labels, some mapping a label to itself.
   task automatic run_random_phase(input label_type base);
      op_type    op;
      label_type key;
      label_type target;
      bit        capped;
      int        links;
      int        roll;
      longint    link_total;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         roll   = $urandom_range(99);
         key    = base + label_type'($urandom_range(WINDOW - 1));
         target = key + label_type'($urandom_range(8, 1));
         if ($urandom_range(99) < 8) target = base + label_type'($urandom_range(WINDOW - 1));
         if (roll < 45) begin
            op = OP_ADD;
         end else if (roll < 85) begin
            op = OP_RESOLVE;
            if ($urandom_range(4) == 0) key = label_type'($urandom_range(LABELS - 1));
         end else if (roll < 89) begin
            op = OP_FLATTEN;
         end else if (roll < 93) begin
            op     = OP_NOP;
            key    = label_type'($urandom_range(LABELS - 1));
            target = label_type'($urandom_range(LABELS - 1));
         end else begin
            op     = OP_ADD;
            key    = label_type'($urandom_range(LABELS - 1));
            target = ($urandom_range(3) == 0) ? key : label_type'($urandom_range(LABELS - 1));
         end

         if (op == OP_RESOLVE) begin
            void'(sb.follow_chain(key, capped, links));
            if (capped && capped_resolves >= CAPPED_RESOLVE_BUDGET) op = OP_ADD;
            else if (capped) capped_resolves++;
         end
         if (op == OP_FLATTEN) begin
            // The estimate walks the map as it stands; the rewrites done during the
            // flatten itself only shorten the later walks.
            link_total = 0;
            for (int i = 0; i < LABELS; i++) begin
               if (sb.entry_valid[i]) begin
                  void'(sb.follow_chain(label_type'(i), capped, links));
                  link_total += links;
               end
            end
            if (link_total > FLATTEN_LINK_BUDGET) op = OP_NOP;
         end
         send_item(op, key, target);
      end
   endtask

   initial begin
      req_chan.valid        = 1'b0;
      req_chan.opcode       = OP_NOP;
      req_chan.key_label    = '0;
      req_chan.target_label = '0;
      rsp_chan.ready        = 1'b0;

      // Reset is held from the start and released at a falling edge. The block then
      // clears its store, with ready low, before it takes the first item.
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, with no idling: an empty table, a label mapped to itself, the
      // extreme labels, a second add on a key that already has an entry, a cycle through
      // the start of the walk, a plain chain, and a foreign cycle that a tail runs into.
      send_item(OP_RESOLVE, 10'd0, 10'd0);
      send_item(OP_NOP, 10'd1023, 10'd1023);
      send_item(OP_ADD, 10'd5, 10'd5);
      send_item(OP_ADD, 10'd0, 10'd1023);
      send_item(OP_ADD, 10'd0, 10'd7);
      send_item(OP_ADD, 10'd1023, 10'd0);
      send_item(OP_RESOLVE, 10'd0, 10'h2AA);
      send_item(OP_RESOLVE, 10'd1023, 10'h155);
      send_item(OP_ADD, 10'd10, 10'd11);
      send_item(OP_ADD, 10'd11, 10'd12);
      send_item(OP_ADD, 10'd12, 10'd13);
      send_item(OP_RESOLVE, 10'd10, 10'd0);
      send_item(OP_RESOLVE, 10'd13, 10'd0);
      send_item(OP_ADD, 10'h155, 10'h2AA);
      send_item(OP_ADD, 10'h2AA, 10'h155);
      send_item(OP_ADD, 10'd100, 10'h155);
      send_item(OP_RESOLVE, 10'd100, 10'd0);
      send_item(OP_RESOLVE, 10'h155, 10'd0);
      send_item(OP_FLATTEN, 10'd0, 10'd0);
      send_item(OP_RESOLVE, 10'd10, 10'd0);
      send_item(OP_RESOLVE, 10'd5, 10'd0);
      send_item(OP_NOP, 10'h155, 10'h2AA);

      // Random part in four pressure phases: none, a mostly idle sender, a mostly
      // stalling receiver, and both sides idling now and then.
      run_random_phase(10'd128);
      send_idle_pct = 88;
      run_random_phase(10'd328);
      send_idle_pct = 0;
      rsp_stall_pct = 88;
      run_random_phase(10'd528);
      send_idle_pct = 28;
      rsp_stall_pct = 28;
      run_random_phase(10'd728);

      @(negedge clock);
      req_chan.valid = 1'b0;

      // Wait for every outstanding response, then a little longer to catch any
      // response that the block should never have produced.
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items: %0d adds (%0d stored), %0d resolves, %0d flattens, %0d no-ops.",
               items_sent, sb.op_seen[OP_ADD], sb.stored_count, sb.op_seen[OP_RESOLVE],
               sb.op_seen[OP_FLATTEN], sb.op_seen[OP_NOP]);
      $display("Compared %0d responses over four pressure mixes; %0d capped walks, %0d errors.",
               sb.checked_count, sb.overflow_count, sb.error_count);
      if (sb.error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
